### rtl/cyclic_quintic_waypoint_trajectory_core_defines.svh
// Assertion macros for the waypoint trajectory core.
// Included by the top level; expects clk and arst_n in scope.
`ifndef CYCLIC_QUINTIC_WAYPOINT_TRAJECTORY_CORE_DEFINES_SVH
`define CYCLIC_QUINTIC_WAYPOINT_TRAJECTORY_CORE_DEFINES_SVH

`define CQWT_ASSERT_IMPL(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define CQWT_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/cqwt_pkg.sv
// Shared types, codes, constants and saturation helpers for the trajectory core.
// No dependencies.
package cqwt_pkg;

	localparam int CQ_WAYPOINTS  = 16;
	localparam int CQ_TICK_BITS  = 16;

	localparam int HW   = 41;
	localparam int HMW  = 40;
	localparam int PW   = 73;
	localparam int NUMW = 57;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic REG_SEGMENT_TICKS  = 1'b0;
	localparam logic REG_WAYPOINT_COUNT = 1'b1;

	localparam logic [15:0] SEGMENT_TICKS_RST  = 16'd1000;
	localparam logic [4:0]  WAYPOINT_COUNT_RST = 5'd2;

	localparam logic signed [HW-1:0] K6   = 41'sd6;
	localparam logic signed [HW-1:0] K10  = 41'sd10;
	localparam logic signed [HW-1:0] K15  = 41'sd15;
	localparam logic signed [HW-1:0] K30  = 41'sd30;
	localparam logic signed [HW-1:0] K60  = 41'sd60;
	localparam logic signed [HW-1:0] K120 = 41'sd120;
	localparam logic signed [HW-1:0] K180 = 41'sd180;

	typedef struct packed {
		logic start;
		logic seg_end;
		logic cap_start;
		logic cap_target;
	} lane_ctl_t;

	typedef struct packed {
		logic [47:0] acc;
		logic [47:0] vel;
		logic [31:0] pos;
	} lane_res_t;

	function automatic logic [31:0] sat32(input logic signed [42:0] s);
		logic [31:0] r;
		if (s > 43'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (s < -43'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	function automatic logic [47:0] sat48(input logic neg, input logic [NUMW-1:0] q);
		logic [47:0] r;
		if (q >= 57'h0_8000_0000_0000) begin
			r = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		end else begin
			r = neg ? (48'd0 - q[47:0]) : q[47:0];
		end
		return r;
	endfunction

endpackage

### rtl/cqwt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by cqwt_blend and cqwt_lane.
module cqwt_div #(
	parameter int NW = 57,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic          done
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] sh_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          geq;

	assign trial = {rem_q, sh_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign geq   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= geq ? diff[DW-1:0] : trial[DW-1:0];
			sh_q  <= {sh_q[NW-2:0], geq};
		end
	end

	assign quo  = sh_q;
	assign done = done_q;

endmodule

### rtl/cqwt_blend.sv
// Blend polynomial unit: tau by division, powers by a shared multiplier, then
// the quintic coefficients of position, velocity and acceleration. Uses cqwt_pkg, cqwt_div.
module cqwt_blend #(
	parameter int TB = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [TB-1:0]                  t,
	input  logic [TB-1:0]                  t_len,
	output logic signed [cqwt_pkg::HW-1:0] hp,
	output logic signed [cqwt_pkg::HW-1:0] hv,
	output logic signed [cqwt_pkg::HW-1:0] ha,
	output logic                           done
);

	localparam logic [2:0] BL_IDLE = 3'd0;
	localparam logic [2:0] BL_DIV  = 3'd1;
	localparam logic [2:0] BL_MUL  = 3'd2;
	localparam logic [2:0] BL_ACC  = 3'd3;
	localparam logic [2:0] BL_COMB = 3'd4;

	localparam logic signed [cqwt_pkg::HW-1:0] K6   = cqwt_pkg::K6;
	localparam logic signed [cqwt_pkg::HW-1:0] K10  = cqwt_pkg::K10;
	localparam logic signed [cqwt_pkg::HW-1:0] K15  = cqwt_pkg::K15;
	localparam logic signed [cqwt_pkg::HW-1:0] K30  = cqwt_pkg::K30;
	localparam logic signed [cqwt_pkg::HW-1:0] K60  = cqwt_pkg::K60;
	localparam logic signed [cqwt_pkg::HW-1:0] K120 = cqwt_pkg::K120;
	localparam logic signed [cqwt_pkg::HW-1:0] K180 = cqwt_pkg::K180;

	logic [2:0]     state_q;
	logic [1:0]     k_q;
	logic           done_q;
	logic [31:0]    tau_q, cur_q, p2_q, p3_q, p4_q, p5_q;
	logic [63:0]    prod_s1;
	logic [TB+31:0] quo;
	logic           div_done;
	logic signed [cqwt_pkg::HW-1:0] hp_q, hv_q, ha_q;
	logic signed [cqwt_pkg::HW-1:0] s1, s2, s3, s4, s5;

	cqwt_div #(.NW(TB + 32), .DW(TB)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.num    ({t, 32'd0}),
		.den    (t_len),
		.quo    (quo),
		.done   (div_done)
	);

	assign s1 = $signed({9'd0, tau_q});
	assign s2 = $signed({9'd0, p2_q});
	assign s3 = $signed({9'd0, p3_q});
	assign s4 = $signed({9'd0, p4_q});
	assign s5 = $signed({9'd0, p5_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BL_IDLE;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				BL_IDLE: begin
					if (start) state_q <= BL_DIV;
				end
				BL_DIV: begin
					if (div_done) begin
						k_q     <= '0;
						state_q <= BL_MUL;
					end
				end
				BL_MUL: state_q <= BL_ACC;
				BL_ACC: begin
					k_q     <= k_q + 1'b1;
					state_q <= (k_q == 2'd3) ? BL_COMB : BL_MUL;
				end
				BL_COMB: begin
					done_q  <= 1'b1;
					state_q <= BL_IDLE;
				end
				default: state_q <= BL_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BL_DIV: begin
				tau_q <= quo[31:0];
				cur_q <= quo[31:0];
			end
			BL_MUL: prod_s1 <= {32'd0, cur_q} * {32'd0, tau_q};
			BL_ACC: begin
				cur_q <= prod_s1[63:32];
				case (k_q)
					2'd0:    p2_q <= prod_s1[63:32];
					2'd1:    p3_q <= prod_s1[63:32];
					2'd2:    p4_q <= prod_s1[63:32];
					default: p5_q <= prod_s1[63:32];
				endcase
			end
			BL_COMB: begin
				hp_q <= K6 * s5 - K15 * s4 + K10 * s3;
				hv_q <= K30 * s4 - K60 * s3 + K30 * s2;
				ha_q <= K120 * s3 - K180 * s2 + K60 * s1;
			end
			default: ;
		endcase
	end

	assign hp   = hp_q;
	assign hv   = hv_q;
	assign ha   = ha_q;
	assign done = done_q;

endmodule

### rtl/cqwt_lane.sv
// One axis lane: waypoint memory, split multiplier for the three blend
// products, velocity and acceleration dividers, saturation. Uses cqwt_pkg, cqwt_div.
module cqwt_lane #(
	parameter int WAYPOINTS = 16,
	parameter int TB        = 16,
	parameter int AW        = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [31:0]                    wr_data,
	input  logic [AW-1:0]                  rd_addr,
	input  cqwt_pkg::lane_ctl_t            ctl,
	input  logic signed [cqwt_pkg::HW-1:0] hp,
	input  logic signed [cqwt_pkg::HW-1:0] hv,
	input  logic signed [cqwt_pkg::HW-1:0] ha,
	input  logic [TB-1:0]                  t_len,
	input  logic [2*TB-1:0]                t_sq,
	output cqwt_pkg::lane_res_t            res,
	output logic                           done
);

	localparam logic [2:0] LN_IDLE = 3'd0;
	localparam logic [2:0] LN_MUL  = 3'd1;
	localparam logic [2:0] LN_ADD  = 3'd2;
	localparam logic [2:0] LN_DIV  = 3'd3;
	localparam logic [2:0] LN_FIN  = 3'd4;
	localparam int PW   = cqwt_pkg::PW;
	localparam int HMW  = cqwt_pkg::HMW;
	localparam int NUMW = cqwt_pkg::NUMW;
	localparam int HW_L = cqwt_pkg::HW;

	logic [31:0] mem [WAYPOINTS];
	logic [31:0] rd_q, qs_q, qf_q;

	logic [2:0]     state_q;
	logic [2:0]     step_q;
	logic           done_q;
	logic           div_go_q;
	logic           dn_q;
	logic [32:0]    dm_q;
	logic [HMW-1:0] hpm_q, hvm_q, ham_q;
	logic           hpn_q, hvn_q, han_q;
	logic [52:0]    pp_s1;
	logic [PW-1:0]  acc_q, prp_q, prv_q, pra_q;
	cqwt_pkg::lane_res_t res_q;

	logic signed [32:0] d;
	logic [32:0]        dmag;
	logic [HW_L-1:0]    hpm, hvm, ham;
	logic [HMW-1:0]     hsel_full;
	logic [19:0]        hsel;
	logic [PW-1:0]      psum;
	logic [NUMW-1:0]    qv, qa;
	logic               dv_done, da_done;
	logic [40:0]        m41, mc;
	logic signed [42:0] psum_pos;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	assign d    = $signed({qf_q[31], qf_q}) - $signed({qs_q[31], qs_q});
	assign dmag = d[32] ? (33'd0 - d) : d;
	assign hpm  = hp[HW_L-1] ? (HW_L'(0) - hp) : hp;
	assign hvm  = hv[HW_L-1] ? (HW_L'(0) - hv) : hv;
	assign ham  = ha[HW_L-1] ? (HW_L'(0) - ha) : ha;

	always_comb begin
		case (step_q[2:1])
			2'd0:    hsel_full = hpm_q;
			2'd1:    hsel_full = hvm_q;
			default: hsel_full = ham_q;
		endcase
		hsel = step_q[0] ? hsel_full[39:20] : hsel_full[19:0];
	end

	assign psum = acc_q + (PW'(pp_s1) << 20);

	cqwt_div #(.NW(NUMW), .DW(2 * TB)) u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (prv_q[PW-1:16]),
		.den    ({{TB{1'b0}}, t_len}),
		.quo    (qv),
		.done   (dv_done)
	);

	cqwt_div #(.NW(NUMW), .DW(2 * TB)) u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (pra_q[PW-1:16]),
		.den    (t_sq),
		.quo    (qa),
		.done   (da_done)
	);

	assign m41      = prp_q[PW-1:32];
	assign mc       = (m41 > 41'h100_0000_0000) ? 41'h100_0000_0000 : m41;
	assign psum_pos = (dn_q != hpn_q) ?
		($signed({{11{qs_q[31]}}, qs_q}) - $signed({2'b00, mc})) :
		($signed({{11{qs_q[31]}}, qs_q}) + $signed({2'b00, mc}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= LN_IDLE;
			step_q   <= '0;
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				LN_IDLE: begin
					if (ctl.start) begin
						if (ctl.seg_end) begin
							done_q <= 1'b1;
						end else begin
							step_q  <= '0;
							state_q <= LN_MUL;
						end
					end
				end
				LN_MUL: state_q <= LN_ADD;
				LN_ADD: begin
					if (step_q == 3'd5) begin
						div_go_q <= 1'b1;
						state_q  <= LN_DIV;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= LN_MUL;
					end
				end
				LN_DIV: begin
					if (dv_done && da_done) state_q <= LN_FIN;
				end
				LN_FIN: begin
					done_q  <= 1'b1;
					state_q <= LN_IDLE;
				end
				default: state_q <= LN_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_start) qs_q <= rd_q;
		if (ctl.cap_target) qf_q <= rd_q;
		case (state_q)
			LN_IDLE: begin
				if (ctl.start) begin
					dn_q  <= d[32];
					dm_q  <= dmag;
					hpm_q <= hpm[HMW-1:0];
					hvm_q <= hvm[HMW-1:0];
					ham_q <= ham[HMW-1:0];
					hpn_q <= hp[HW_L-1];
					hvn_q <= hv[HW_L-1];
					han_q <= ha[HW_L-1];
					if (ctl.seg_end) begin
						res_q.pos <= qf_q;
						res_q.vel <= '0;
						res_q.acc <= '0;
					end
				end
			end
			LN_MUL: pp_s1 <= {20'd0, dm_q} * {33'd0, hsel};
			LN_ADD: begin
				if (!step_q[0]) begin
					acc_q <= PW'(pp_s1);
				end else begin
					case (step_q[2:1])
						2'd0:    prp_q <= psum;
						2'd1:    prv_q <= psum;
						default: pra_q <= psum;
					endcase
				end
			end
			LN_FIN: begin
				res_q.pos <= cqwt_pkg::sat32(psum_pos);
				res_q.vel <= cqwt_pkg::sat48(dn_q != hvn_q, qv);
				res_q.acc <= cqwt_pkg::sat48(dn_q != han_q, qa);
			end
			default: ;
		endcase
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

### rtl/cyclic_quintic_waypoint_trajectory_core.sv
// Three-axis quintic trajectory generator cycling through up to sixteen stored
// waypoints. A load beat writes one waypoint and a restart beat returns to waypoint
// zero. A tick beat yields one result beat; except on the last tick of a segment,
// it passes through the bit-serial tau divider (TICK_BITS + 32 steps) and the
// 57-step velocity and acceleration dividers in each axis lane. One item is in
// work at a time; a finished result waits in the output register while the next
// beat is taken. Uses cqwt_pkg, cqwt_blend, cqwt_lane and the assertion macro header.
`include "cyclic_quintic_waypoint_trajectory_core_defines.svh"

module cyclic_quintic_waypoint_trajectory_core #(
	parameter int WAYPOINTS = cqwt_pkg::CQ_WAYPOINTS,
	parameter int TICK_BITS = cqwt_pkg::CQ_TICK_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // wp_index, wp_x, wp_y, wp_z
	input  logic [1:0]   s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [391:0] m_tdata,  // pos_x..z, vel_x..z, acc_x..z, segment_number
	output logic         m_tlast   // segment_end
);

	localparam int TB    = TICK_BITS;
	localparam int AW    = (WAYPOINTS > 1) ? $clog2(WAYPOINTS) : 1;
	localparam int LIMIT = (WAYPOINTS < 16) ? WAYPOINTS : 16;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD0  = 3'd1;
	localparam logic [2:0] ST_RD1  = 3'd2;
	localparam logic [2:0] ST_RD2  = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_LANE = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]      state_q;
	logic [15:0]     seg_ticks_q;
	logic [4:0]      wp_count_q;
	logic [TB-1:0]   tick_q;
	logic [3:0]      cur_seg_q;
	logic [TB-1:0]   t_len_q;
	logic [TB-1:0]   t_q;
	logic [2*TB-1:0] t_sq_q;
	logic [3:0]      start_q, target_q;
	logic            end_q;
	logic            m_tvalid_q, m_tlast_q;
	logic [391:0]    m_tdata_q;

	logic [1:0]   op;
	logic [3:0]   wp_index;
	logic         acc_in, in_range, out_load;
	logic [32:0]  st33, tmax33, tcl33;
	logic [TB-1:0] t_len_c;
	logic [4:0]   cnt_c, sp1;
	logic [3:0]   target_c;
	logic [TB:0]  t_c;
	logic         end_c;
	logic [AW+3:0] wa_ext, sa_ext, ta_ext;

	logic signed [cqwt_pkg::HW-1:0] hp, hv, ha;
	logic                           bl_done, bl_start;
	cqwt_pkg::lane_ctl_t            ln_ctl;
	cqwt_pkg::lane_res_t            ln_res [3];
	logic [2:0]                     ln_done;
	logic [31:0]                    wp_in [3];
	logic [AW-1:0]                  rd_addr;

	assign op       = s_tuser;
	assign wp_index = s_tdata[3:0];
	assign wp_in[0] = s_tdata[35:4];
	assign wp_in[1] = s_tdata[67:36];
	assign wp_in[2] = s_tdata[99:68];
	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign in_range = (33'(wp_index) < 33'(WAYPOINTS));

	assign st33    = 33'(seg_ticks_q);
	assign tmax33  = (33'd1 << TB) - 33'd1;
	assign tcl33   = (st33 == 33'd0) ? 33'd1 : ((st33 > tmax33) ? tmax33 : st33);
	assign t_len_c = tcl33[TB-1:0];

	assign cnt_c    = (wp_count_q == 5'd0) ? 5'd1 :
		((33'(wp_count_q) > 33'(LIMIT)) ? 5'(LIMIT) : wp_count_q);
	assign sp1      = {1'b0, cur_seg_q} + 5'd1;
	assign target_c = (sp1 >= cnt_c) ? 4'd0 : sp1[3:0];
	assign t_c      = {1'b0, tick_q} + 1'b1;
	assign end_c    = t_c >= {1'b0, t_len_c};

	assign wa_ext  = {{AW{1'b0}}, wp_index};
	assign sa_ext  = {{AW{1'b0}}, start_q};
	assign ta_ext  = {{AW{1'b0}}, target_q};
	assign rd_addr = (state_q == ST_RD0) ? sa_ext[AW-1:0] : ta_ext[AW-1:0];

	assign bl_start = acc_in && (op == cqwt_pkg::OP_TICK) && !end_c;

	assign ln_ctl.start      = (state_q == ST_WAIT) && (end_q || bl_done);
	assign ln_ctl.seg_end    = end_q;
	assign ln_ctl.cap_start  = (state_q == ST_RD1);
	assign ln_ctl.cap_target = (state_q == ST_RD2);

	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	cqwt_blend #(.TB(TB)) u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bl_start),
		.t      (t_c[TB-1:0]),
		.t_len  (t_len_c),
		.hp     (hp),
		.hv     (hv),
		.ha     (ha),
		.done   (bl_done)
	);

	for (genvar g = 0; g < 3; g++) begin : g_lane
		cqwt_lane #(.WAYPOINTS(WAYPOINTS), .TB(TB), .AW(AW)) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (acc_in && (op == cqwt_pkg::OP_LOAD) && in_range),
			.wr_addr (wa_ext[AW-1:0]),
			.wr_data (wp_in[g]),
			.rd_addr (rd_addr),
			.ctl     (ln_ctl),
			.hp      (hp),
			.hv      (hv),
			.ha      (ha),
			.t_len   (t_len_q),
			.t_sq    (t_sq_q),
			.res     (ln_res[g]),
			.done    (ln_done[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_ticks_q <= cqwt_pkg::SEGMENT_TICKS_RST;
			wp_count_q  <= cqwt_pkg::WAYPOINT_COUNT_RST;
			tick_q      <= '0;
			cur_seg_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cqwt_pkg::REG_SEGMENT_TICKS:  seg_ticks_q <= cfg_data;
					cqwt_pkg::REG_WAYPOINT_COUNT: wp_count_q  <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						case (op)
							cqwt_pkg::OP_TICK: state_q <= ST_RD0;
							cqwt_pkg::OP_RESTART: begin
								tick_q    <= '0;
								cur_seg_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_RD0:  state_q <= ST_RD1;
				ST_RD1:  state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (ln_ctl.start) state_q <= ST_LANE;
				end
				ST_LANE: begin
					if (&ln_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						if (end_q) begin
							tick_q    <= '0;
							cur_seg_q <= target_q;
						end else begin
							tick_q <= t_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && (op == cqwt_pkg::OP_TICK)) begin
			t_len_q  <= t_len_c;
			t_q      <= t_c[TB-1:0];
			start_q  <= cur_seg_q;
			target_q <= target_c;
			end_q    <= end_c;
		end
		t_sq_q <= {{TB{1'b0}}, t_len_q} * {{TB{1'b0}}, t_len_q};
		if (out_load) begin
			m_tdata_q <= {4'd0, start_q,
				ln_res[2].acc, ln_res[1].acc, ln_res[0].acc,
				ln_res[2].vel, ln_res[1].vel, ln_res[0].vel,
				ln_res[2].pos, ln_res[1].pos, ln_res[0].pos};
			m_tlast_q <= end_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`CQWT_ASSERT_IMPL(a_lane_sync, ln_done[0], ln_done[1] && ln_done[2], "axis lanes out of step")
	`CQWT_ASSERT_IMPL(a_out_free, out_load, !m_tvalid_q || m_tready, "result register overwritten")
	`CQWT_ASSERT_NEXT(a_tick_busy, acc_in && (op == cqwt_pkg::OP_TICK), !s_tready, "tick not held busy")
	`CQWT_ASSERT_NEXT(a_seg_wrap, out_load && end_q, tick_q == '0, "tick count kept past segment end")

endmodule
